>>> design/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants of the 1-Wire bus master core: the sequencer
// phases, the timing register set, and the item and result layouts.
// ----------------------------------------------------------------------------
package owbm_pkg;

	localparam int DurW     = 10;
	localparam int CfgIdxW  = 3;
	localparam int InDataW  = 16;
	localparam int InUserW  = 3;
	localparam int OutDataW = 16;

	typedef logic [DurW-1:0] dur_t;

	typedef struct packed {
		dur_t reset_low_us;
		dur_t presence_wait_us;
		dur_t reset_recover_us;
		dur_t write_low_us;
		dur_t write_hold_us;
		dur_t read_low_us;
		dur_t read_sample_us;
		dur_t read_recover_us;
	} cfg_t;

	localparam cfg_t CfgDefault = '{
		reset_low_us:     10'd500,
		presence_wait_us: 10'd70,
		reset_recover_us: 10'd500,
		write_low_us:     10'd10,
		write_hold_us:    10'd50,
		read_low_us:      10'd5,
		read_sample_us:   10'd5,
		read_recover_us:  10'd50
	};

	localparam logic [CfgIdxW-1:0] CFG_RESET_LOW     = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_PRESENCE_WAIT = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_RESET_RECOVER = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_WRITE_LOW     = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_WRITE_HOLD    = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_READ_LOW      = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_READ_SAMPLE   = 3'd6;
	localparam logic [CfgIdxW-1:0] CFG_READ_RECOVER  = 3'd7;

	localparam logic [1:0] MODE_RESET = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	typedef enum logic [9:0] {
		PH_IDLE     = 10'b00_0000_0001,
		PH_RST_LOW  = 10'b00_0000_0010,
		PH_RST_WAIT = 10'b00_0000_0100,
		PH_RST_REC  = 10'b00_0000_1000,
		PH_WR_LOW   = 10'b00_0001_0000,
		PH_WR_HOLD  = 10'b00_0010_0000,
		PH_WR_REC   = 10'b00_0100_0000,
		PH_RD_LOW   = 10'b00_1000_0000,
		PH_RD_WAIT  = 10'b01_0000_0000,
		PH_RD_REC   = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] mode;
		logic [7:0] cmd_byte;
		logic       line_level;
	} item_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       presence;
		logic       done_res;
		logic       busy_res;
		logic       drive_low;
	} result_t;

endpackage

>>> design/owbm_seq.sv
// ----------------------------------------------------------------------------
// owbm_seq
// Slot sequencer of the 1-Wire master. Each step consumes one microsecond
// tick and produces that tick's bus drive, status and received data.
// ----------------------------------------------------------------------------
module owbm_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  owbm_pkg::item_t  item,
	input  owbm_pkg::cfg_t   cfg,
	output owbm_pkg::result_t result
);
	import owbm_pkg::*;

	phase_t     phase_q, phase_d;
	dur_t       tick_q, tick_d;
	logic [2:0] bit_q, bit_d;
	logic [7:0] shift_q, shift_d;
	logic       pres_q, pres_d;
	logic [7:0] recv_q, recv_d;
	logic       drive, busy, done;

	function automatic logic ends(input dur_t tc, input dur_t d);
		return ({1'b0, tc} + 11'd1) >= {1'b0, d};
	endfunction

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		pres_d  = pres_q;
		recv_d  = recv_q;
		drive   = 1'b0;
		done    = 1'b0;

		if (phase_q == PH_IDLE && item.cmd_valid) begin
			case (item.mode)
				MODE_RESET: begin
					phase_d = PH_RST_LOW;
					tick_d  = '0;
					bit_d   = '0;
					shift_d = '0;
				end
				MODE_WRITE: begin
					phase_d = PH_WR_LOW;
					tick_d  = '0;
					bit_d   = '0;
					shift_d = item.cmd_byte;
				end
				MODE_READ: begin
					phase_d = PH_RD_LOW;
					tick_d  = '0;
					bit_d   = '0;
					shift_d = '0;
				end
				default: ;
			endcase
		end

		busy = (phase_d != PH_IDLE);

		unique case (phase_d)
			PH_IDLE: ;
			PH_RST_LOW: begin
				drive = 1'b1;
				if (ends(tick_d, cfg.reset_low_us)) begin
					tick_d  = '0;
					phase_d = PH_RST_WAIT;
				end else begin
					tick_d = tick_d + 10'd1;
				end
			end
			PH_RST_WAIT: begin
				if (ends(tick_d, cfg.presence_wait_us)) begin
					tick_d  = '0;
					phase_d = PH_RST_REC;
				end else begin
					tick_d = tick_d + 10'd1;
				end
			end
			PH_RST_REC: begin
				if (tick_d == '0) begin
					pres_d = ~item.line_level;
				end
				if (ends(tick_d, cfg.reset_recover_us)) begin
					tick_d  = '0;
					phase_d = PH_IDLE;
					done    = 1'b1;
				end else begin
					tick_d = tick_d + 10'd1;
				end
			end
			PH_WR_LOW: begin
				drive = 1'b1;
				if (ends(tick_d, cfg.write_low_us)) begin
					tick_d  = '0;
					phase_d = PH_WR_HOLD;
				end else begin
					tick_d = tick_d + 10'd1;
				end
			end
			PH_WR_HOLD: begin
				drive = ~shift_d[0];
				if (ends(tick_d, cfg.write_hold_us)) begin
					tick_d  = '0;
					phase_d = PH_WR_REC;
				end else begin
					tick_d = tick_d + 10'd1;
				end
			end
			PH_WR_REC: begin
				tick_d  = '0;
				shift_d = {1'b0, shift_d[7:1]};
				if (bit_d == 3'd7) begin
					phase_d = PH_IDLE;
					done    = 1'b1;
					bit_d   = '0;
				end else begin
					bit_d   = bit_d + 3'd1;
					phase_d = PH_WR_LOW;
				end
			end
			PH_RD_LOW: begin
				drive = 1'b1;
				if (ends(tick_d, cfg.read_low_us)) begin
					tick_d  = '0;
					phase_d = PH_RD_WAIT;
				end else begin
					tick_d = tick_d + 10'd1;
				end
			end
			PH_RD_WAIT: begin
				if (ends(tick_d, cfg.read_sample_us)) begin
					tick_d  = '0;
					phase_d = PH_RD_REC;
				end else begin
					tick_d = tick_d + 10'd1;
				end
			end
			PH_RD_REC: begin
				if (tick_d == '0) begin
					shift_d = {item.line_level, shift_d[7:1]};
				end
				if (ends(tick_d, cfg.read_recover_us)) begin
					tick_d = '0;
					if (bit_d == 3'd7) begin
						recv_d  = shift_d;
						phase_d = PH_IDLE;
						done    = 1'b1;
						bit_d   = '0;
					end else begin
						bit_d   = bit_d + 3'd1;
						phase_d = PH_RD_LOW;
					end
				end else begin
					tick_d = tick_d + 10'd1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				busy    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			pres_q  <= 1'b0;
			recv_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			pres_q  <= pres_d;
			recv_q  <= recv_d;
		end
	end

	assign result = '{
		read_byte: recv_d,
		presence:  pres_d,
		done_res:  done,
		busy_res:  busy,
		drive_low: drive
	};

endmodule

>>> design/one_wire_bus_master_core.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_core
// 1-Wire bus master driven by one stream transfer per microsecond tick.
// A tick's input is held in the input register and its result in the output register.
// Throughput: one tick per cycle unless the output stalls; the slot sequencer advances once per tick.
// An input register and an output register decouple the two stream sides.
// Reset: asynchronous, active low; the sequencer goes idle, status and
// read data clear, and the timing registers take their default values.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [7:0] cmd_byte, [8] line_level, [15:9] zero
	input  logic [owbm_pkg::InDataW-1:0]   s_axis_tdata,
	// [0] cmd_valid, [2:1] mode
	input  logic [owbm_pkg::InUserW-1:0]   s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [0] drive_low, [1] busy_res, [2] done_res, [3] presence,
	// [11:4] read_byte, [15:12] zero
	output logic [owbm_pkg::OutDataW-1:0]  m_axis_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [owbm_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [owbm_pkg::DurW-1:0]      cfg_data
);
	import owbm_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_q;
	result_t res_d;
	logic    out_valid_q;
	logic    in_xfer;
	logic    advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CfgDefault;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RESET_LOW:     cfg_q.reset_low_us     <= cfg_data;
				CFG_PRESENCE_WAIT: cfg_q.presence_wait_us <= cfg_data;
				CFG_RESET_RECOVER: cfg_q.reset_recover_us <= cfg_data;
				CFG_WRITE_LOW:     cfg_q.write_low_us     <= cfg_data;
				CFG_WRITE_HOLD:    cfg_q.write_hold_us    <= cfg_data;
				CFG_READ_LOW:      cfg_q.read_low_us      <= cfg_data;
				CFG_READ_SAMPLE:   cfg_q.read_sample_us   <= cfg_data;
				CFG_READ_RECOVER:  cfg_q.read_recover_us  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || !out_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.cmd_valid  <= s_axis_tuser[0];
			item_s1.mode       <= s_axis_tuser[2:1];
			item_s1.cmd_byte   <= s_axis_tdata[7:0];
			item_s1.line_level <= s_axis_tdata[8];
		end
	end

	owbm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, res_q};

endmodule

>>> design/owbm_checker.sv
// ----------------------------------------------------------------------------
// owbm_port_checks
// Port-level checks of the 1-Wire master core, bound to the top level.
// ----------------------------------------------------------------------------
module owbm_port_checks (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [owbm_pkg::OutDataW-1:0]  m_axis_tdata
);
	import owbm_pkg::*;

	// A result waiting downstream must not hold off the input side.
	a_ready_passes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output is ready");

	// The bus is only pulled low while a command is running.
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[1])
		else $error("bus driven low outside a command");

	// A command finishes on a tick that is still counted as busy.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[2]) |-> m_axis_tdata[1])
		else $error("done without busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

endmodule

bind one_wire_bus_master_core owbm_port_checks u_owbm_port_checks (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
